// ===== rtl/core/pfma_pkg.sv =====
// shared types and constants of the prime field modular alu
package pfma_pkg;

  localparam int unsigned FIELD_W   = 64;
  localparam int unsigned DEF_WIDTH = 64;
  localparam int unsigned OP_W      = 3;

  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_NEG = 3'd3,
    OP_POW = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_EXEC,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_POW_NEXT,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/prime_field_modular_alu.sv =====
// prime field alu: add, sub, mul, neg and pow modulo a configured modulus
//
// An item is taken when start_i is high and busy_o is low; busy_o then stays high
// until the single result appears on result_o with done_o high for one cycle, and
// the receiver cannot stall it. All arithmetic runs through one shared modular
// add/subtract unit, one WIDTH-bit step per cycle. Both operands are first reduced
// bit-serially (power reduces only the base). Add, subtract and negate then pass
// the reduced operands through the unit. Multiply is shift-and-add: a doubling
// for each multiplier bit, followed by an add of the multiplicand when that bit
// is set. Power runs square-and-multiply over all WIDTH exponent bits, each bit
// costing one square plus one multiply when set. A modulus of 0 or 1, or an
// unknown op, gives 0 in the cycle after the item is taken. The modulus register
// is written through cfg_we_i/cfg_wdata_i; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module prime_field_modular_alu #(
  parameter int unsigned WIDTH = pfma_pkg::DEF_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [pfma_pkg::OP_W-1:0]     op_i,
  input  logic [pfma_pkg::FIELD_W-1:0]  operand_a_i,
  input  logic [pfma_pkg::FIELD_W-1:0]  operand_b_i,
  input  logic                          cfg_we_i,
  input  logic [pfma_pkg::FIELD_W-1:0]  cfg_wdata_i,
  output logic                          done_o,
  output logic [pfma_pkg::FIELD_W-1:0]  result_o
);

  localparam int unsigned CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  pfma_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0]        modulus_q;
  logic [pfma_pkg::OP_W-1:0] op_q, op_d;
  logic [WIDTH-1:0]        a_q, a_d;
  logic [WIDTH-1:0]        b_q, b_d;
  logic [WIDTH-1:0]        acc_q, acc_d;
  logic [WIDTH-1:0]        mx_q, mx_d;
  logic [WIDTH-1:0]        my_q, my_d;
  logic [WIDTH-1:0]        res_q, res_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           ecnt_q, ecnt_d;
  logic                    sq_q, sq_d;

  // shared modular add/sub unit
  logic [WIDTH-1:0] u_x, u_y, u_yv, u_alt, u_res;
  logic             u_cin, u_sub, u_sel;
  logic [WIDTH:0]   u_sum;

  always_comb begin
    u_x   = acc_q;
    u_y   = acc_q;
    u_cin = 1'b0;
    u_sub = 1'b0;
    unique case (state_q)
      pfma_pkg::ST_RED_A: u_cin = a_q[WIDTH-1];
      pfma_pkg::ST_RED_B: u_cin = b_q[WIDTH-1];
      pfma_pkg::ST_EXEC: begin
        u_x = a_q;
        u_y = b_q;
        priority case (op_q)
          pfma_pkg::OP_SUB: u_sub = 1'b1;
          pfma_pkg::OP_NEG: begin
            u_x   = '0;
            u_y   = a_q;
            u_sub = 1'b1;
          end
          default: u_sub = 1'b0;
        endcase
      end
      pfma_pkg::ST_MUL_ADD: u_y = mx_q;
      default: u_cin = 1'b0;
    endcase
  end

  assign u_yv  = u_sub ? ~u_y : u_y;
  assign u_sum = {1'b0, u_x} + {1'b0, u_yv} + (WIDTH+1)'(u_sub | u_cin);
  assign u_alt = u_sum[WIDTH-1:0] + (u_sub ? modulus_q : (~modulus_q + WIDTH'(1)));
  // add: take away p once when the sum reaches p; sub: add p back on borrow
  assign u_sel = u_sub ? ~u_sum[WIDTH] : (u_sum >= {1'b0, modulus_q});
  assign u_res = u_sel ? u_alt : u_sum[WIDTH-1:0];

  logic p_small;
  assign p_small = (modulus_q[WIDTH-1:1] == '0);

  logic op_known;
  assign op_known = (op_i == pfma_pkg::OP_ADD) || (op_i == pfma_pkg::OP_SUB) ||
                    (op_i == pfma_pkg::OP_MUL) || (op_i == pfma_pkg::OP_NEG) ||
                    (op_i == pfma_pkg::OP_POW);

  // next state and datapath
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    mx_d    = mx_q;
    my_d    = my_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    ecnt_d  = ecnt_q;
    sq_d    = sq_q;
    unique case (state_q)
      pfma_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d  = op_i;
          a_d   = operand_a_i[WIDTH-1:0];
          b_d   = operand_b_i[WIDTH-1:0];
          acc_d = '0;
          cnt_d = CNT_LAST;
          if (p_small || !op_known) begin
            res_d   = '0;
            state_d = pfma_pkg::ST_DONE;
          end else begin
            state_d = pfma_pkg::ST_RED_A;
          end
        end
      end
      pfma_pkg::ST_RED_A: begin
        acc_d = u_res;
        a_d   = a_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          a_d   = u_res;
          acc_d = '0;
          cnt_d = CNT_LAST;
          if (op_q == pfma_pkg::OP_POW) begin
            // exponent is taken as given, no reduction
            res_d   = WIDTH'(1);
            mx_d    = WIDTH'(1);
            my_d    = WIDTH'(1);
            ecnt_d  = CNT_LAST;
            sq_d    = 1'b1;
            state_d = pfma_pkg::ST_MUL_DBL;
          end else begin
            state_d = pfma_pkg::ST_RED_B;
          end
        end
      end
      pfma_pkg::ST_RED_B: begin
        acc_d = u_res;
        b_d   = b_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          b_d   = u_res;
          acc_d = '0;
          cnt_d = CNT_LAST;
          if (op_q == pfma_pkg::OP_MUL) begin
            mx_d    = a_q;
            my_d    = u_res;
            state_d = pfma_pkg::ST_MUL_DBL;
          end else begin
            state_d = pfma_pkg::ST_EXEC;
          end
        end
      end
      pfma_pkg::ST_EXEC: begin
        res_d   = u_res;
        state_d = pfma_pkg::ST_DONE;
      end
      pfma_pkg::ST_MUL_DBL, pfma_pkg::ST_MUL_ADD: begin
        acc_d = u_res;
        if ((state_q == pfma_pkg::ST_MUL_DBL) && my_q[WIDTH-1]) begin
          state_d = pfma_pkg::ST_MUL_ADD;
        end else if (cnt_q == '0) begin
          res_d   = u_res;
          state_d = (op_q == pfma_pkg::OP_POW) ? pfma_pkg::ST_POW_NEXT : pfma_pkg::ST_DONE;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          my_d    = my_q << 1;
          state_d = pfma_pkg::ST_MUL_DBL;
        end
      end
      pfma_pkg::ST_POW_NEXT: begin
        acc_d = '0;
        cnt_d = CNT_LAST;
        if (sq_q && b_q[WIDTH-1]) begin
          // multiply by the base after squaring for a set exponent bit
          mx_d    = a_q;
          my_d    = res_q;
          sq_d    = 1'b0;
          state_d = pfma_pkg::ST_MUL_DBL;
        end else if (ecnt_q == '0) begin
          state_d = pfma_pkg::ST_DONE;
        end else begin
          ecnt_d  = ecnt_q - CW'(1);
          b_d     = b_q << 1;
          mx_d    = res_q;
          my_d    = res_q;
          sq_d    = 1'b1;
          state_d = pfma_pkg::ST_MUL_DBL;
        end
      end
      pfma_pkg::ST_DONE: state_d = pfma_pkg::ST_IDLE;
      default: state_d = pfma_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = (state_q != pfma_pkg::ST_IDLE);
    done_o = (state_q == pfma_pkg::ST_DONE);
  end

  assign result_o = pfma_pkg::FIELD_W'(res_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfma_pkg::ST_IDLE;
      modulus_q <= pfma_pkg::MODULUS_RESET[WIDTH-1:0];
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i[WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
    ecnt_q <= ecnt_d;
    sq_q   <= sq_d;
  end

  // an accepted item raises busy_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted but block not busy");

  // a result strobe is followed by idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block still busy after result");

  // results stay inside the field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (p_small || (res_q < modulus_q)))
    else $error("result not reduced");

  // the add half of a multiply step only follows a doubling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfma_pkg::ST_MUL_ADD) |-> ($past(state_q) == pfma_pkg::ST_MUL_DBL))
    else $error("multiply add step out of order");

  // the shared unit never leaves the multiply accumulator out of range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pfma_pkg::ST_MUL_DBL) || (state_q == pfma_pkg::ST_MUL_ADD)) |->
      (acc_q < modulus_q))
    else $error("multiply accumulator out of range");

endmodule
